>>> sv/wsd_pkg.sv
package wsd_pkg;

	localparam int unsigned LenW = 64;
	localparam int unsigned KeyW = 32;

	localparam logic [LenW-1:0] MAX_LEN_RESET = LenW'(8 * 1024 * 1024);

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_FIN      = 2'd1;
	localparam logic [1:0] ERR_UNMASKED = 2'd2;
	localparam logic [1:0] ERR_LONG     = 2'd3;

	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	localparam logic [3:0] EXT_BYTES16 = 4'd2;
	localparam logic [3:0] EXT_BYTES64 = 4'd8;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload_byte;
		logic [3:0] opcode;
		logic       last_byte;
		logic [1:0] error_code;
	} res_t;

endpackage

>>> sv/wsd_in_stage.sv
module wsd_in_stage
	import wsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	input  logic [7:0] data_byte,
	input  logic       hold,
	output logic       data_stall,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic take;

	assign data_stall = valid_s1 && hold;
	assign take       = data_valid && !data_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= data_byte;
		end
	end

endmodule

>>> sv/wsd_parser.sv
module wsd_parser
	import wsd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [LenW-1:0] cfg_wr_data,
	input  logic            fire,
	input  logic [7:0]      byte_s1,
	output logic            res_valid,
	output res_t            res
);

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT,
		PH_MASK,
		PH_DATA,
		PH_HALT
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [3:0]        opcode_q, opcode_d;
	logic [3:0]        ext_left_q, ext_left_d;
	logic [LenW-1:0]   remaining_q, remaining_d;
	logic [KeyW-1:0]   key_q, key_d;
	logic [1:0]        pos_q, pos_d;
	logic [LenW-1:0]   max_len_q;
	logic              emit;
	logic [1:0]        kind_d;
	logic [1:0]        err_d;
	logic [7:0]        out_byte_d;
	logic              last_d;
	logic [7:0]        key_byte;

	assign key_byte = key_q[{~pos_q, 3'b000} +: 8];

	always_comb begin
		phase_d     = phase_q;
		opcode_d    = opcode_q;
		ext_left_d  = ext_left_q;
		remaining_d = remaining_q;
		key_d       = key_q;
		pos_d       = pos_q;
		emit        = 1'b0;
		kind_d      = KIND_DATA;
		err_d       = ERR_NONE;
		out_byte_d  = 8'd0;
		last_d      = 1'b0;
		unique case (phase_q)
			PH_HDR0: begin
				opcode_d = byte_s1[3:0];
				if (!byte_s1[7]) begin
					phase_d = PH_HALT;
					emit    = 1'b1;
					kind_d  = KIND_ERROR;
					err_d   = ERR_FIN;
				end else begin
					phase_d = PH_HDR1;
				end
			end
			PH_HDR1: begin
				if (!byte_s1[7]) begin
					phase_d = PH_HALT;
					emit    = 1'b1;
					kind_d  = KIND_ERROR;
					err_d   = ERR_UNMASKED;
				end else begin
					remaining_d = '0;
					key_d       = '0;
					pos_d       = 2'd0;
					if (byte_s1[6:0] == LEN7_EXT16) begin
						ext_left_d = EXT_BYTES16;
						phase_d    = PH_EXT;
					end else if (byte_s1[6:0] == LEN7_EXT64) begin
						ext_left_d = EXT_BYTES64;
						phase_d    = PH_EXT;
					end else begin
						remaining_d = {{(LenW-7){1'b0}}, byte_s1[6:0]};
						if (remaining_d > max_len_q) begin
							phase_d = PH_HALT;
							emit    = 1'b1;
							kind_d  = KIND_ERROR;
							err_d   = ERR_LONG;
						end else begin
							phase_d = PH_MASK;
						end
					end
				end
			end
			PH_EXT: begin
				remaining_d = {remaining_q[LenW-9:0], byte_s1};
				ext_left_d  = ext_left_q - 4'd1;
				if (ext_left_q == 4'd1) begin
					if (remaining_d > max_len_q) begin
						phase_d = PH_HALT;
						emit    = 1'b1;
						kind_d  = KIND_ERROR;
						err_d   = ERR_LONG;
					end else begin
						phase_d = PH_MASK;
					end
				end
			end
			PH_MASK: begin
				key_d = {key_q[KeyW-9:0], byte_s1};
				if (pos_q == 2'd3) begin
					pos_d = 2'd0;
					if (remaining_q == '0) begin
						phase_d = PH_HDR0;
						emit    = 1'b1;
						kind_d  = KIND_EMPTY;
					end else begin
						phase_d = PH_DATA;
					end
				end else begin
					pos_d = pos_q + 2'd1;
				end
			end
			PH_DATA: begin
				remaining_d = remaining_q - LenW'(1);
				last_d      = (remaining_q == LenW'(1));
				pos_d       = pos_q + 2'd1;
				emit        = 1'b1;
				kind_d      = KIND_DATA;
				out_byte_d  = byte_s1 ^ key_byte;
				if (last_d) begin
					phase_d = PH_HDR0;
				end
			end
			PH_HALT: begin
			end
			default: begin
				phase_d = PH_HALT;
			end
		endcase
	end

	assign res_valid        = fire && emit;
	assign res.kind         = kind_d;
	assign res.payload_byte = out_byte_d;
	assign res.opcode       = opcode_d;
	assign res.last_byte    = last_d;
	assign res.error_code   = err_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			opcode_q    <= 4'd0;
			ext_left_q  <= 4'd0;
			remaining_q <= '0;
			key_q       <= '0;
			pos_q       <= 2'd0;
		end else if (fire) begin
			phase_q     <= phase_d;
			opcode_q    <= opcode_d;
			ext_left_q  <= ext_left_d;
			remaining_q <= remaining_d;
			key_q       <= key_d;
			pos_q       <= pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

`ifndef SYNTHESIS
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |-> !res_valid)
		else $error("result produced after protocol error");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("left halt state without reset");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res.kind == KIND_ERROR) == (res.error_code != ERR_NONE)))
		else $error("error code does not match result kind");

	a_ext_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_EXT |-> ext_left_q != 4'd0)
		else $error("extended length phase with no bytes left");

	a_last_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last_byte |-> res.kind == KIND_DATA
			##1 phase_q == PH_HDR0)
		else $error("last byte flag outside payload or frame not closed");
`endif

endmodule

>>> sv/wsd_out_stage.sv
module wsd_out_stage
	import wsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       res_valid,
	input  res_t       res,
	input  logic       result_stall,
	output logic       hold,
	output logic       result_valid,
	output res_t       result_q
);

	assign hold = result_valid && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (!hold) begin
			result_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && res_valid) begin
			result_q <= res;
		end
	end

endmodule

>>> sv/websocket_frame_deframer_core.sv
// Each accepted byte goes into the input register; a result goes into the result
// register. Throughput: one byte per cycle while the output is not stalled; the
// header parse and unmasking fit between the input register and the result register.
// Reset (arst_n low): frame parse restarts at the first header byte, the
// maximum payload length returns to 8 MiB, both stages empty.
module websocket_frame_deframer_core
	import wsd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [LenW-1:0] cfg_wr_data,
	input  logic            data_valid,
	output logic            data_stall,
	input  logic [7:0]      data_byte,
	output logic            result_valid,
	input  logic            result_stall,
	output logic [1:0]      kind,
	output logic [7:0]      payload_byte,
	output logic [3:0]      opcode,
	output logic            last_byte,
	output logic [1:0]      error_code
);

	logic       hold;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fire;
	logic       res_valid;
	res_t       res;
	res_t       result_q;

	assign fire = valid_s1 && !hold;

	wsd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_byte  (data_byte),
		.hold       (hold),
		.data_stall (data_stall),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1)
	);

	wsd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.byte_s1     (byte_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	wsd_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.result_stall (result_stall),
		.hold         (hold),
		.result_valid (result_valid),
		.result_q     (result_q)
	);

	assign kind         = result_q.kind;
	assign payload_byte = result_q.payload_byte;
	assign opcode       = result_q.opcode;
	assign last_byte    = result_q.last_byte;
	assign error_code   = result_q.error_code;

endmodule

>>> test/tb_websocket_frame_deframer_core.sv
module tb_websocket_frame_deframer_core;
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		ST_HDR0, ST_HDR1, ST_EXT, ST_MASK, ST_DATA, ST_HALT
	} parse_st_t;

	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		res_t       r;
	} step_t;

	localparam res_t NO_RES = '0;
	localparam int N_DIR = 24;

	localparam step_t DIR_TAB [N_DIR] = '{
		// empty frame, opcode 0, zero key
		'{8'h80, 1'b0, NO_RES}, '{8'h80, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
		'{8'h00, 1'b1, '{KIND_EMPTY, 8'h00, 4'h0, 1'b0, ERR_NONE}},
		// one byte, opcode F, all-ones key
		'{8'h8F, 1'b0, NO_RES}, '{8'h81, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
		'{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
		'{8'h00, 1'b1, '{KIND_DATA, 8'hFF, 4'hF, 1'b1, ERR_NONE}},
		// 16-bit extended length of 3, reserved bits set
		'{8'hF2, 1'b0, NO_RES}, '{8'hFE, 1'b0, NO_RES},
		'{8'h00, 1'b0, NO_RES}, '{8'h03, 1'b0, NO_RES},
		'{8'h12, 1'b0, NO_RES}, '{8'h34, 1'b0, NO_RES},
		'{8'h56, 1'b0, NO_RES}, '{8'h78, 1'b0, NO_RES},
		'{8'hAB, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES}
	};

	logic            clk;
	logic            arst_n;
	logic            cfg_wr_en = 1'b0;
	logic [LenW-1:0] cfg_wr_data = '0;
	logic            data_valid = 1'b0;
	logic            data_stall;
	logic [7:0]      data_byte = '0;
	logic            result_valid;
	logic            result_stall = 1'b0;
	logic [1:0]      kind;
	logic [7:0]      payload_byte;
	logic [3:0]      opcode;
	logic            last_byte;
	logic [1:0]      error_code;

	logic row_typed = 1'b0;
	res_t row_res = '0;

	res_t pending_results [$];
	int   mismatches = 0;
	int   send_idle = 0;
	int   recv_idle = 0;
	int   seg_bytes = 0;

	parse_st_t       ps = ST_HDR0;
	logic [3:0]      cur_op = '0;
	logic [3:0]      ext_left = '0;
	logic [63:0]     remain = '0;
	logic [KeyW-1:0] key = '0;
	logic [1:0]      kpos = '0;
	logic [LenW-1:0] len_limit = MAX_LEN_RESET;

	websocket_frame_deframer_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.data_valid  (data_valid),
		.data_stall  (data_stall),
		.data_byte   (data_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind        (kind),
		.payload_byte(payload_byte),
		.opcode      (opcode),
		.last_byte   (last_byte),
		.error_code  (error_code)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 400000);
		$display("websocket_frame_deframer_core test failed");
		$finish;
	end

	function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
		logic [7:0] kb;
		r = NO_RES;
		deframe_byte = 1'b0;
		case (ps)
			ST_HDR0: begin
				cur_op = b[3:0];
				if (!b[7]) begin
					ps = ST_HALT;
					r = '{KIND_ERROR, 8'h00, cur_op, 1'b0, ERR_FIN};
					deframe_byte = 1'b1;
				end else begin
					ps = ST_HDR1;
				end
			end
			ST_HDR1: begin
				if (!b[7]) begin
					ps = ST_HALT;
					r = '{KIND_ERROR, 8'h00, cur_op, 1'b0, ERR_UNMASKED};
					deframe_byte = 1'b1;
				end else begin
					remain = '0;
					key = '0;
					kpos = '0;
					if (b[6:0] == LEN7_EXT16) begin
						ext_left = EXT_BYTES16;
						ps = ST_EXT;
					end else if (b[6:0] == LEN7_EXT64) begin
						ext_left = EXT_BYTES64;
						ps = ST_EXT;
					end else begin
						remain = {57'd0, b[6:0]};
						if (remain > len_limit) begin
							ps = ST_HALT;
							r = '{KIND_ERROR, 8'h00, cur_op, 1'b0, ERR_LONG};
							deframe_byte = 1'b1;
						end else begin
							ps = ST_MASK;
						end
					end
				end
			end
			ST_EXT: begin
				remain = {remain[55:0], b};
				ext_left = ext_left - 4'd1;
				if (ext_left == 4'd0) begin
					if (remain > len_limit) begin
						ps = ST_HALT;
						r = '{KIND_ERROR, 8'h00, cur_op, 1'b0, ERR_LONG};
						deframe_byte = 1'b1;
					end else begin
						ps = ST_MASK;
					end
				end
			end
			ST_MASK: begin
				key = {key[23:0], b};
				if (kpos == 2'd3) begin
					kpos = '0;
					if (remain == '0) begin
						ps = ST_HDR0;
						r = '{KIND_EMPTY, 8'h00, cur_op, 1'b0, ERR_NONE};
						deframe_byte = 1'b1;
					end else begin
						ps = ST_DATA;
					end
				end else begin
					kpos = kpos + 2'd1;
				end
			end
			ST_DATA: begin
				kb = key[8 * (3 - int'(kpos)) +: 8];
				remain = remain - 64'd1;
				kpos = kpos + 2'd1;
				r = '{KIND_DATA, b ^ kb, cur_op, remain == '0, ERR_NONE};
				if (remain == '0)
					ps = ST_HDR0;
				deframe_byte = 1'b1;
			end
			default: ;
		endcase
	endfunction

	task automatic note_mismatch(input string what, input res_t want, input res_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected kind=%0d byte=%02h op=%0h last=%0d err=%0d,",
				what, want.kind, want.payload_byte, want.opcode, want.last_byte,
				want.error_code,
				" got kind=%0d byte=%02h op=%0h last=%0d err=%0d",
				got.kind, got.payload_byte, got.opcode, got.last_byte,
				got.error_code);
	endtask

	always @(posedge clk) begin : beat_check
		res_t pr;
		res_t got;
		res_t want;
		bit   has;
		if (arst_n) begin
			if (cfg_wr_en)
				len_limit = cfg_wr_data;
			if (data_valid && !data_stall) begin
				has = deframe_byte(data_byte, pr);
				if (row_typed)
					pending_results.insert(pending_results.size(), row_res);
				else if (has)
					pending_results.insert(pending_results.size(), pr);
			end
			if (result_valid && !result_stall) begin
				got = '{kind, payload_byte, opcode, last_byte, error_code};
				if (pending_results.size() == 0) begin
					note_mismatch("unexpected beat", NO_RES, got);
				end else begin
					want = pending_results.pop_front();
					if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
						got.opcode !== want.opcode || got.last_byte !== want.last_byte ||
						got.error_code !== want.error_code)
						note_mismatch("mismatch", want, got);
				end
			end
		end
	end

	always @(posedge clk)
		result_stall <= ($urandom_range(99) < recv_idle);

	task automatic send_byte(input logic [7:0] b, input logic typed, input res_t r);
		while ($urandom_range(99) < send_idle) begin
			data_valid <= 1'b0;
			@(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		row_typed <= typed;
		row_res <= r;
		@(posedge clk);
		while (data_stall)
			@(posedge clk);
		seg_bytes++;
	endtask

	task automatic drain_results();
		data_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic [LenW-1:0] v);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic int unsigned frame_len(input logic [LenW-1:0] lim);
		int unsigned cap;
		cap = (lim < 64'd40) ? int'(lim) : 40;
		if ($urandom_range(9) == 0)
			return cap;
		return $urandom_range(0, (cap < 12) ? cap : 12);
	endfunction

	task automatic put_frame(input int unsigned len);
		logic [63:0] len64;
		logic [31:0] mk;
		int unsigned pick;
		len64 = 64'(len);
		pick = $urandom_range(99);
		send_byte({1'b1, 3'($urandom_range(7)), 4'($urandom_range(15))}, 1'b0, NO_RES);
		if (pick < 70 && len < 126) begin
			send_byte({1'b1, 7'(len)}, 1'b0, NO_RES);
		end else if (pick < 85) begin
			send_byte({1'b1, LEN7_EXT16}, 1'b0, NO_RES);
			send_byte(len64[15:8], 1'b0, NO_RES);
			send_byte(len64[7:0], 1'b0, NO_RES);
		end else begin
			send_byte({1'b1, LEN7_EXT64}, 1'b0, NO_RES);
			for (int i = 7; i >= 0; i--)
				send_byte(len64[8 * i +: 8], 1'b0, NO_RES);
		end
		mk = $urandom;
		for (int i = 0; i < 4; i++)
			send_byte(mk[31 - 8 * i -: 8], 1'b0, NO_RES);
		for (int unsigned i = 0; i < len; i++)
			send_byte(8'($urandom), 1'b0, NO_RES);
	endtask

	initial begin : stim
		logic [LenW-1:0] lim;
		logic [3:0]      op;
		logic [6:0]      short_lim;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_idle = 35;
		recv_idle = 69;
		for (int i = 0; i < N_DIR; i++)
			send_byte(DIR_TAB[i].b, DIR_TAB[i].typed, DIR_TAB[i].r);

		for (int seg = 0; seg < 6; seg++) begin
			case (seg / 2)
				0: begin send_idle = 35; recv_idle = 69; end
				1: begin send_idle = 69; recv_idle = 35; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			case (seg)
				0: lim = '0;
				1: lim = '1;
				2: lim = 64'($urandom_range(1, 40));
				3: lim = {$urandom, $urandom};
				4: lim = 64'($urandom_range(0, 8));
				default: lim = MAX_LEN_RESET - 64'd1;
			endcase
			write_limit(lim);
			seg_bytes = 0;
			while (seg_bytes < 90) begin
				put_frame(frame_len(lim));
				if ($urandom_range(11) == 0)
					drain_results();
			end
		end

		// one protocol error at the end; everything after it is dropped
		op = 4'($urandom_range(15));
		case ($urandom_range(2))
			0: send_byte({1'b0, 3'($urandom_range(7)), op}, 1'b1,
				'{KIND_ERROR, 8'h00, op, 1'b0, ERR_FIN});
			1: begin
				send_byte({1'b1, 3'($urandom_range(7)), op}, 1'b0, NO_RES);
				send_byte({1'b0, 7'($urandom_range(127))}, 1'b1,
					'{KIND_ERROR, 8'h00, op, 1'b0, ERR_UNMASKED});
			end
			default: begin
				if ($urandom_range(1) == 0) begin
					short_lim = 7'($urandom_range(0, 124));
					write_limit({57'd0, short_lim});
					send_byte({1'b1, 3'($urandom_range(7)), op}, 1'b0, NO_RES);
					send_byte({1'b1, short_lim + 7'd1}, 1'b1,
						'{KIND_ERROR, 8'h00, op, 1'b0, ERR_LONG});
				end else begin
					write_limit('1 - 64'd1);
					send_byte({1'b1, 3'($urandom_range(7)), op}, 1'b0, NO_RES);
					send_byte({1'b1, LEN7_EXT64}, 1'b0, NO_RES);
					repeat (7) send_byte(8'hFF, 1'b0, NO_RES);
					send_byte(8'hFF, 1'b1, '{KIND_ERROR, 8'h00, op, 1'b0, ERR_LONG});
				end
			end
		endcase
		repeat (10) send_byte(8'($urandom), 1'b0, NO_RES);

		drain_results();
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("websocket_frame_deframer_core test passed");
		else
			$display("websocket_frame_deframer_core test failed");
		$finish;
	end

endmodule
